>>> sv/led_matrix_digit_display_timer_top_assert.svh
// assertion macros used by the checker file
`ifndef LED_MATRIX_DIGIT_DISPLAY_TIMER_TOP_ASSERT_SVH
`define LED_MATRIX_DIGIT_DISPLAY_TIMER_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define LMDT_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lmdt check failed");

// condition implies consequence in the next cycle
`define LMDT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lmdt check failed");

`endif

>>> sv/lmdt_pkg.sv
package lmdt_pkg;

    // input request fields
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  digit;
        logic [15:0] duration_ms;
        logic        flash;
        logic        power_ok;
        logic        lipo_detected;
    } in_item_t;

    // one controller register write
    typedef struct packed {
        logic [3:0] reg_addr;
        logic [7:0] reg_data;
        logic       last;
    } out_item_t;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SHOW  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;
    localparam logic [1:0] CMD_REARM = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_INTENSITY = 2'd0;
    localparam logic [1:0] CFG_BLINK     = 2'd1;
    localparam logic [1:0] CFG_REARM     = 2'd2;

    // controller register addresses
    localparam logic [3:0] ADDR_DECODE    = 4'h9;
    localparam logic [3:0] ADDR_INTENSITY = 4'hA;
    localparam logic [3:0] ADDR_SCAN      = 4'hB;
    localparam logic [3:0] ADDR_SHUTDOWN  = 4'hC;
    localparam logic [3:0] ADDR_TEST      = 4'hF;
    localparam logic [3:0] ADDR_ROW_LAST  = 4'h8;

    // positions in the write sequence; a row-only sequence starts at the glyph rows
    localparam logic [4:0] POS_SCAN       = 5'd0;
    localparam logic [4:0] POS_DECODE     = 5'd1;
    localparam logic [4:0] POS_SHUTDOWN   = 5'd2;
    localparam logic [4:0] POS_TEST       = 5'd3;
    localparam logic [4:0] POS_INTENSITY  = 5'd4;
    localparam logic [4:0] POS_ZERO_ROWS  = 5'd5;
    localparam logic [4:0] POS_GLYPH_ROWS = 5'd13;
    localparam logic [4:0] POS_LAST       = 5'd20;

    localparam int ROW_COUNT = 8;

    // font rom, row bits msb at the left
    localparam logic [7:0] FONT [16][ROW_COUNT] = '{
        '{8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
        '{8'h0C, 8'h1C, 8'h3C, 8'h6C, 8'h0C, 8'h0C, 8'h0C, 8'h0C},
        '{8'h38, 8'h6C, 8'h06, 8'h06, 8'h0C, 8'h30, 8'h60, 8'h7E},
        '{8'h38, 8'h6C, 8'h06, 8'h0C, 8'h06, 8'h06, 8'h66, 8'h3C},
        '{8'h0C, 8'h1C, 8'h2C, 8'h2C, 8'h4C, 8'h7E, 8'h0C, 8'h0C},
        '{8'h3E, 8'h30, 8'h60, 8'h7C, 8'h06, 8'h06, 8'h66, 8'h3C},
        '{8'h3C, 8'h66, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h66, 8'h3C},
        '{8'h7E, 8'h06, 8'h0C, 8'h0C, 8'h18, 8'h18, 8'h18, 8'h18},
        '{8'h3C, 8'h66, 8'h66, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h3C},
        '{8'h3C, 8'h66, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h66, 8'h3C},
        '{8'h7E, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7E},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // register write at a given sequence position
    function automatic out_item_t write_at(logic [4:0] pos, logic glyph_on,
                                           logic [3:0] glyph, logic [3:0] inten);
        out_item_t  w;
        logic [4:0] row;
        w.last     = (pos == POS_LAST);
        w.reg_addr = '0;
        w.reg_data = '0;
        row        = '0;
        case (pos)
            POS_SCAN:
            begin
                w.reg_addr = ADDR_SCAN;
                w.reg_data = 8'h07;
            end
            POS_DECODE:
            begin
                w.reg_addr = ADDR_DECODE;
            end
            POS_SHUTDOWN:
            begin
                w.reg_addr = ADDR_SHUTDOWN;
                w.reg_data = 8'h01;
            end
            POS_TEST:
            begin
                w.reg_addr = ADDR_TEST;
            end
            POS_INTENSITY:
            begin
                w.reg_addr = ADDR_INTENSITY;
                w.reg_data = {4'b0, inten};
            end
            default:
            begin
                if (pos < POS_GLYPH_ROWS)
                begin
                    row        = pos - POS_ZERO_ROWS;
                    w.reg_addr = row[3:0] + 4'd1;
                end
                else
                begin
                    row        = pos - POS_GLYPH_ROWS;
                    w.reg_addr = row[3:0] + 4'd1;
                    w.reg_data = glyph_on ? FONT[glyph][row[2:0]] : 8'h00;
                end
            end
        endcase
        return w;
    endfunction

endpackage

>>> sv/led_matrix_digit_display_timer_top.sv
// channel | direction | handshake            | payload
// in      | request   | in_valid / in_ready  | in_data (in_item_t)
// out     | result    | out_valid / out_ready| out_data (out_item_t)
// cfg     | write     | cfg_wr_en            | cfg_index, cfg_data
// a request's state update is done at acceptance
// writes leave one per cycle while out_ready holds: 8 for a draw or blank, 21 for init, none otherwise
// a request with writes holds the input off until its last write enters the output register
// rst_n clears timers, blink state and configuration to their defaults
// a stalled output holds its write; the sequencer waits behind it
module led_matrix_digit_display_timer_top
    import lmdt_pkg::*;
#(
    parameter int GLYPH_COUNT = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

    // configuration
    logic [3:0]  intensity_reg;
    logic [15:0] blink_period_reg;
    logic [15:0] rearm_timeout_reg;

    // timer state
    logic        to_active_reg, to_active_next;
    logic [15:0] to_elapsed_reg, to_elapsed_next;
    logic [15:0] to_limit_reg, to_limit_next;
    logic        bl_active_reg, bl_active_next;
    logic [15:0] bl_elapsed_reg, bl_elapsed_next;
    logic        bl_shown_reg, bl_shown_next;
    logic [3:0]  bl_glyph_reg, bl_glyph_next;

    // write sequencer
    logic        job_valid_reg;
    logic [4:0]  job_pos_reg;
    logic        job_glyph_on_reg;
    logic [3:0]  job_glyph_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic        accept;
    logic        advance;
    logic        new_job;
    logic [4:0]  new_pos;
    logic        new_glyph_on;
    logic [3:0]  new_glyph;
    logic [15:0] to_inc;
    logic [15:0] bl_inc;
    logic        show_ok;

    assign advance   = job_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !job_valid_reg || (advance && job_pos_reg == POS_LAST);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign to_inc  = (to_active_reg && to_elapsed_reg != 16'hFFFF) ?
                     to_elapsed_reg + 16'd1 : to_elapsed_reg;
    assign bl_inc  = (bl_active_reg && bl_elapsed_reg != 16'hFFFF) ?
                     bl_elapsed_reg + 16'd1 : bl_elapsed_reg;
    assign show_ok = ({1'b0, in_data.digit} < GLYPH_LIMIT) && in_data.power_ok
                     && in_data.lipo_detected;

    // command decode and timer update
    always_comb
    begin
        to_active_next  = to_active_reg;
        to_elapsed_next = to_elapsed_reg;
        to_limit_next   = to_limit_reg;
        bl_active_next  = bl_active_reg;
        bl_elapsed_next = bl_elapsed_reg;
        bl_shown_next   = bl_shown_reg;
        bl_glyph_next   = bl_glyph_reg;
        new_job         = 1'b0;
        new_pos         = POS_GLYPH_ROWS;
        new_glyph_on    = 1'b0;
        new_glyph       = '0;
        case (in_data.cmd)
            CMD_TICK:
            begin
                if (!in_data.power_ok || (to_active_reg && to_inc >= to_limit_reg))
                begin
                    to_active_next  = 1'b0;
                    to_elapsed_next = '0;
                    bl_active_next  = 1'b0;
                    bl_elapsed_next = '0;
                    new_job         = 1'b1;
                end
                else
                begin
                    to_elapsed_next = to_inc;
                    bl_elapsed_next = bl_inc;
                    if (bl_active_reg && bl_inc >= blink_period_reg)
                    begin
                        bl_elapsed_next = '0;
                        bl_shown_next   = !bl_shown_reg;
                        if (bl_shown_reg)
                        begin
                            new_job = 1'b1;
                        end
                        else if (({5'b0, bl_glyph_reg} < GLYPH_LIMIT)
                                 && in_data.lipo_detected)
                        begin
                            new_job      = 1'b1;
                            new_glyph_on = 1'b1;
                            new_glyph    = bl_glyph_reg;
                        end
                    end
                end
            end
            CMD_SHOW:
            begin
                to_active_next  = 1'b0;
                to_elapsed_next = '0;
                bl_active_next  = 1'b0;
                bl_elapsed_next = '0;
                new_job         = 1'b1;
                if (show_ok)
                begin
                    new_glyph_on   = 1'b1;
                    new_glyph      = in_data.digit[3:0];
                    to_limit_next  = in_data.duration_ms;
                    to_active_next = (in_data.duration_ms != 16'd0);
                    if (in_data.flash)
                    begin
                        bl_active_next = 1'b1;
                        bl_glyph_next  = in_data.digit[3:0];
                        bl_shown_next  = 1'b1;
                    end
                end
            end
            CMD_INIT:
            begin
                to_active_next  = 1'b0;
                to_elapsed_next = '0;
                bl_active_next  = 1'b0;
                bl_elapsed_next = '0;
                new_job         = 1'b1;
                new_pos         = POS_SCAN;
            end
            default:
            begin
                to_limit_next   = rearm_timeout_reg;
                to_active_next  = 1'b1;
                to_elapsed_next = '0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intensity_reg     <= 4'd15;
            blink_period_reg  <= 16'd500;
            rearm_timeout_reg <= 16'd5000;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INTENSITY: intensity_reg     <= cfg_data[3:0];
                CFG_BLINK:     blink_period_reg  <= cfg_data;
                CFG_REARM:     rearm_timeout_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // timer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            to_active_reg  <= 1'b0;
            to_elapsed_reg <= '0;
            to_limit_reg   <= '0;
            bl_active_reg  <= 1'b0;
            bl_elapsed_reg <= '0;
            bl_shown_reg   <= 1'b0;
            bl_glyph_reg   <= '0;
        end
        else if (accept)
        begin
            to_active_reg  <= to_active_next;
            to_elapsed_reg <= to_elapsed_next;
            to_limit_reg   <= to_limit_next;
            bl_active_reg  <= bl_active_next;
            bl_elapsed_reg <= bl_elapsed_next;
            bl_shown_reg   <= bl_shown_next;
            bl_glyph_reg   <= bl_glyph_next;
        end
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // a new sequence starts as the previous one hands over its last write
            if (accept && new_job)
            begin
                job_valid_reg <= 1'b1;
                job_pos_reg   <= new_pos;
            end
            else if (advance)
            begin
                job_pos_reg <= job_pos_reg + 5'd1;
                if (job_pos_reg == POS_LAST)
                begin
                    job_valid_reg <= 1'b0;
                end
            end
        end
    end

    // sequencer payload
    always_ff @(posedge clk)
    begin
        if (accept && new_job)
        begin
            job_glyph_on_reg <= new_glyph_on;
            job_glyph_reg    <= new_glyph;
        end
        if (advance)
        begin
            out_reg <= write_at(job_pos_reg, job_glyph_on_reg, job_glyph_reg,
                                intensity_reg);
        end
    end

endmodule

>>> sv/lmdt_checker.sv
`include "led_matrix_digit_display_timer_top_assert.svh"

module lmdt_checker
    import lmdt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a waiting request stays offered
    `LMDT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)

    // a stalled result stays offered
    `LMDT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // input held off with nothing offered means a write is on its way
    `LMDT_ASSERT_NEXT(a_progress, clk, rst_n, !in_ready && !out_valid, out_valid)

    // a sequence keeps flowing until its last write
    `LMDT_ASSERT_NEXT(a_no_gap, clk, rst_n, out_valid && out_ready && !out_data.last,
                      out_valid)

    // every sequence ends on the bottom row
    `LMDT_ASSERT_NOW(a_last_row, clk, rst_n, out_valid && out_data.last,
                     out_data.reg_addr == ADDR_ROW_LAST)

endmodule

bind led_matrix_digit_display_timer_top lmdt_checker u_lmdt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> tb/sv/led_matrix_digit_display_timer_top_test.sv
module led_matrix_digit_display_timer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lmdt_pkg::*;

    localparam int GLYPH_COUNT   = 11;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;

    // fixed data bytes of the set-up sequence
    localparam logic [7:0] SCAN_ALL_ROWS = 8'h07;
    localparam logic [7:0] DECODE_NONE   = 8'h00;
    localparam logic [7:0] SHUTDOWN_RUN  = 8'h01;
    localparam logic [7:0] TEST_OFF      = 8'h00;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_INTENSITY;
    logic [15:0] cfg_data  = '0;

    led_matrix_digit_display_timer_top #(
        .GLYPH_COUNT(GLYPH_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tracks timer and blink state, predicts the register writes of each request
    class matrix_write_scoreboard;
        logic [3:0]  intensity;
        logic [15:0] blink_period;
        logic [15:0] rearm_limit;
        bit          tmo_active;
        logic [15:0] tmo_elapsed;
        logic [15:0] tmo_limit;
        bit          blink_on;
        logic [15:0] blink_elapsed;
        bit          blink_shown;
        logic [3:0]  blink_glyph;
        out_item_t   pending_writes[$];
        out_item_t   step_writes[$];
        int          mismatch_count;

        function new();
            intensity      = 4'd15;
            blink_period   = 16'd500;
            rearm_limit    = 16'd5000;
            tmo_active     = 1'b0;
            tmo_elapsed    = '0;
            tmo_limit      = '0;
            blink_on       = 1'b0;
            blink_elapsed  = '0;
            blink_shown    = 1'b0;
            blink_glyph    = '0;
            mismatch_count = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [15:0] value);
            case (index)
                CFG_INTENSITY: intensity = value[3:0];
                CFG_BLINK:     blink_period = value;
                CFG_REARM:     rearm_limit = value;
                default:       ;
            endcase
        endfunction

        function void add_write(logic [3:0] addr, logic [7:0] data);
            out_item_t w;
            w.reg_addr = addr;
            w.reg_data = data;
            w.last     = 1'b0;
            step_writes.push_back(w);
        endfunction

        function void add_rows(bit lit, logic [3:0] glyph);
            for (int r = 0; r < ROW_COUNT; r++)
                add_write(4'(r + 1), lit ? FONT[glyph][r] : 8'h00);
        endfunction

        function void stop_timers();
            tmo_active    = 1'b0;
            tmo_elapsed   = '0;
            blink_on      = 1'b0;
            blink_elapsed = '0;
        endfunction

        function void blank_rows();
            stop_timers();
            add_rows(1'b0, 4'd0);
        endfunction

        function void note_request(in_item_t req);
            out_item_t w;
            step_writes.delete();
            case (req.cmd)
                CMD_TICK:
                begin
                    if (!req.power_ok)
                        blank_rows();
                    else
                    begin
                        // saturating elapsed counters
                        if (tmo_active && tmo_elapsed != 16'hFFFF)
                            tmo_elapsed++;
                        if (blink_on && blink_elapsed != 16'hFFFF)
                            blink_elapsed++;
                        if (tmo_active && tmo_elapsed >= tmo_limit)
                            blank_rows();
                        else if (blink_on && blink_elapsed >= blink_period)
                        begin
                            blink_elapsed = '0;
                            if (blink_shown)
                            begin
                                blink_shown = 1'b0;
                                add_rows(1'b0, 4'd0);
                            end
                            else
                            begin
                                blink_shown = 1'b1;
                                if (blink_glyph < GLYPH_COUNT && req.lipo_detected)
                                    add_rows(1'b1, blink_glyph);
                            end
                        end
                    end
                end
                CMD_SHOW:
                begin
                    stop_timers();
                    if (req.digit < GLYPH_COUNT && req.power_ok && req.lipo_detected)
                    begin
                        add_rows(1'b1, req.digit[3:0]);
                        tmo_limit = req.duration_ms;
                        if (req.duration_ms != 0)
                            tmo_active = 1'b1;
                        if (req.flash)
                        begin
                            blink_on    = 1'b1;
                            blink_glyph = req.digit[3:0];
                            blink_shown = 1'b1;
                        end
                    end
                    else
                        add_rows(1'b0, 4'd0);
                end
                CMD_INIT:
                begin
                    add_write(ADDR_SCAN, SCAN_ALL_ROWS);
                    add_write(ADDR_DECODE, DECODE_NONE);
                    add_write(ADDR_SHUTDOWN, SHUTDOWN_RUN);
                    add_write(ADDR_TEST, TEST_OFF);
                    add_write(ADDR_INTENSITY, {4'd0, intensity});
                    add_rows(1'b0, 4'd0);
                    blank_rows();
                end
                default:
                begin
                    tmo_limit   = rearm_limit;
                    tmo_active  = 1'b1;
                    tmo_elapsed = '0;
                end
            endcase
            // final write of the request carries last
            for (int i = 0; i < step_writes.size(); i++)
            begin
                w      = step_writes[i];
                w.last = (i == step_writes.size() - 1);
                pending_writes.push_back(w);
            end
        endfunction

        function void check_write(out_item_t got);
            out_item_t want;
            if (pending_writes.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected write: addr %h data %h last %b",
                             got.reg_addr, got.reg_data, got.last);
                mismatch_count++;
                return;
            end
            want = pending_writes.pop_front();
            if (got.reg_addr !== want.reg_addr || got.reg_data !== want.reg_data ||
                got.last !== want.last)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("write mismatch: expected %h %h %b, got %h %h %b",
                             want.reg_addr, want.reg_data, want.last,
                             got.reg_addr, got.reg_data, got.last);
                mismatch_count++;
            end
        endfunction
    endclass

    matrix_write_scoreboard sb = new();

    int burst_left  = 0;
    int hold_asked  = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int cycle_count = 0;

    // receiver: checks accepted writes, stalls on its own pattern
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_write(out_data);
        if (hold_asked != hold_seen)
        begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(5, 60);
            end
            mode_left--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic in_item_t make_req(logic [1:0] cmd, logic [7:0] digit,
                                          logic [15:0] dur, bit flash, bit pwr, bit lipo);
        in_item_t req;
        req.cmd           = cmd;
        req.digit         = digit;
        req.duration_ms   = dur;
        req.flash         = flash;
        req.power_ok      = pwr;
        req.lipo_detected = lipo;
        return req;
    endfunction

    function automatic in_item_t noise_req();
        logic [31:0] bits;
        in_item_t    req;
        bits = $urandom;
        req  = bits[$bits(in_item_t)-1:0];
        return req;
    endfunction

    // sender: bursts of requests with random gaps
    task automatic send_request(in_item_t req);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(req);
    endtask

    // drain all writes, then let a request without writes finish
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_registers(logic [3:0] inten, logic [15:0] blink, logic [15:0] rearm);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_INTENSITY;
        cfg_data  <= {12'd0, inten};
        @(posedge clk);
        sb.set_register(CFG_INTENSITY, {12'd0, inten});
        cfg_index <= CFG_BLINK;
        cfg_data  <= blink;
        @(posedge clk);
        sb.set_register(CFG_BLINK, blink);
        cfg_index <= CFG_REARM;
        cfg_data  <= rearm;
        @(posedge clk);
        sb.set_register(CFG_REARM, rearm);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly show followed by a run of ticks, with init, rearm and noise mixed in
    task automatic random_phase(int count);
        in_item_t req;
        int       sent;
        int       ticks;
        int       pick;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 9);
            req  = noise_req();
            if (pick <= 5)
            begin
                req.cmd = CMD_SHOW;
                if ($urandom_range(0, 7) == 0)
                    req.digit = 8'($urandom_range(GLYPH_COUNT, 255));
                else
                    req.digit = 8'($urandom_range(0, GLYPH_COUNT - 1));
                case ($urandom_range(0, 5))
                    0, 1:    req.duration_ms = '0;
                    5:       req.duration_ms = 16'($urandom_range(0, 65535));
                    default: req.duration_ms = 16'($urandom_range(1, 25));
                endcase
                req.power_ok      = ($urandom_range(0, 9) != 0);
                req.lipo_detected = ($urandom_range(0, 9) != 0);
                send_request(req);
                sent++;
                if ($urandom_range(0, 4) == 0)
                begin
                    req     = noise_req();
                    req.cmd = CMD_REARM;
                    send_request(req);
                    sent++;
                end
                ticks = $urandom_range(1, 12);
                repeat (ticks)
                begin
                    req               = noise_req();
                    req.cmd           = CMD_TICK;
                    req.power_ok      = ($urandom_range(0, 19) != 0);
                    req.lipo_detected = ($urandom_range(0, 6) != 0);
                    send_request(req);
                    sent++;
                end
            end
            else if (pick == 6)
            begin
                req.cmd = CMD_INIT;
                send_request(req);
                sent++;
            end
            else if (pick == 7)
            begin
                req.cmd = CMD_REARM;
                send_request(req);
                sent++;
                ticks = $urandom_range(1, 8);
                repeat (ticks)
                begin
                    req          = noise_req();
                    req.cmd      = CMD_TICK;
                    req.power_ok = 1'b1;
                    send_request(req);
                    sent++;
                end
            end
            else
            begin
                send_request(req);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: init, glyph extremes, invalid glyphs, power and battery loss
        send_request(make_req(CMD_INIT, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_SHOW, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_SHOW, 8'd10, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_SHOW, 8'd11, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_SHOW, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        send_request(make_req(CMD_SHOW, 8'd8, 16'd0, 1'b0, 1'b0, 1'b1));
        send_request(make_req(CMD_SHOW, 8'd8, 16'd0, 1'b0, 1'b1, 1'b0));
        // short timeout runs out on the second tick
        send_request(make_req(CMD_SHOW, 8'd4, 16'd2, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        // tick without power blanks
        send_request(make_req(CMD_SHOW, 8'd6, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b0, 1'b1));

        // low extremes: blink every tick, zero rearm timeout expires at once
        set_registers(4'd0, 16'd1, 16'd0);
        send_request(make_req(CMD_INIT, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_SHOW, 8'd7, 16'd0, 1'b1, 1'b1, 1'b1));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b1, 1'b0));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_REARM, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));

        // zero blink period toggles on every tick until the timeout ends it
        set_registers(4'd15, 16'd0, 16'hFFFF);
        send_request(make_req(CMD_SHOW, 8'd9, 16'd3, 1'b1, 1'b1, 1'b1));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));
        send_request(make_req(CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1));

        // random phases over several settings
        set_registers(4'($urandom_range(0, 15)), 16'($urandom_range(1, 6)),
                      16'($urandom_range(0, 20)));
        random_phase(30);

        // long receiver hold-off while requests keep coming
        set_registers(4'($urandom_range(0, 15)), 16'($urandom_range(2, 8)),
                      16'($urandom_range(5, 30)));
        hold_asked++;
        random_phase(30);

        set_registers(4'd15, 16'hFFFF, 16'hFFFF);
        random_phase(20);

        set_registers(4'($urandom_range(0, 15)), 16'($urandom_range(1, 4)),
                      16'($urandom_range(0, 10)));
        random_phase(30);

        settle();
        if (sb.mismatch_count == 0 && sb.pending_writes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/lmdt_pkg.sv
sv/led_matrix_digit_display_timer_top.sv
sv/lmdt_checker.sv
tb/sv/led_matrix_digit_display_timer_top_test.sv
